### design/rpwf_pkg.sv
// ----------------------------------------------------------------------------
// rpwf_pkg
// Shared types and constants of the replicate-padded window filter.
// ----------------------------------------------------------------------------
package rpwf_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_SIZE  = 7;
	localparam int ROW_W         = 13;
	localparam int HEIGHT_LIMIT  = 4096;
	localparam int ACC_W         = 18;
	localparam int CFG_W         = 13;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2,
		REG_MSIZE  = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		MODE_MEAN    = 2'd0,
		MODE_SMOOTH  = 2'd1,
		MODE_SHARPEN = 2'd2,
		MODE_GAUSS   = 2'd3
	} filter_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_LAST,
		S_DIV,
		S_RES
	} state_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_FLUSH = 1'b1
	} req_type_t;

endpackage

### design/replicate_pad_window_filter.sv
// ----------------------------------------------------------------------------
// replicate_pad_window_filter
// Raster-order window filter with edge replication, line store in one RAM.
// ----------------------------------------------------------------------------
// Each request is taken in the idle state. A pixel is written to the line
// store in that cycle; then the block checks whether the next output is
// complete. If so it reads the N*N (mean) or 3*3 window from the single
// line store port, one pixel per cycle, and accumulates it, with a
// reciprocal multiply in mean mode. A pixel past the last row is not
// written and gives a result with status set. The output register lets the
// next request in while a result waits to be taken. Counters restart on any
// register write; line store contents are kept.
module replicate_pad_window_filter #(
	parameter int MAX_WIDTH = rpwf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_SIZE  = rpwf_pkg::DEF_MAX_SIZE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [rpwf_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic [7:0]                pixel_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                pixel_out,
	output logic                      frame_end,
	output logic                      status
);
	import rpwf_pkg::*;

	localparam int MAX_ODD   = ((MAX_SIZE - 1) | 1);
	localparam int ROW_SLOTS = MAX_ODD + 1;
	localparam int SW        = $clog2(ROW_SLOTS);
	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH     = 2 ** (SW + CW);
	localparam int RSH       = 32;
	localparam int RW        = 29;
	localparam longint RONE  = longint'(1) << RSH;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [1:0]  mode_q;
	logic [2:0]  msize_q;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_s1;
	logic       rd_s1;
	logic signed [7:0] wt_s1;

	state_t state_q, state_d;

	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [WW-1:0]    in_col_q, out_col_q;
	logic [SW-1:0]    in_slot_q, out_slot_q;
	logic signed [4:0] dy_q, dx_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [7:0] quo_q;
	logic       drop_q;

	logic       out_valid_q;
	logic [7:0] pix_q;
	logic       fend_q;
	logic       stat_q;

	// effective configuration
	logic [12:0]      w13;
	logic [WW-1:0]    eff_w;
	logic [ROW_W-1:0] eff_h;
	logic [3:0]       n0, n1, eff_n;
	logic [3:0]       p;
	logic [SW:0]      slots;

	always_comb begin
		if (width_q == 11'd0) w13 = 13'd1;
		else if ({2'b0, width_q} > 13'(MAX_WIDTH)) w13 = 13'(MAX_WIDTH);
		else w13 = {2'b0, width_q};
		eff_w = WW'(w13);
		if (height_q == 13'd0) eff_h = 13'd1;
		else if (height_q > 13'(HEIGHT_LIMIT)) eff_h = 13'(HEIGHT_LIMIT);
		else eff_h = height_q;
		n0 = (msize_q < 3'd3) ? 4'd3 : {1'b0, msize_q};
		n1 = n0 | 4'd1;
		eff_n = (n1 > 4'(MAX_ODD)) ? 4'(MAX_ODD) : n1;
		p = (mode_q == MODE_MEAN) ? {1'b0, eff_n[3:1]} : 4'd1;
		slots = (SW + 1)'({p, 1'b0} + 5'd2);
	end

	logic accept;
	logic out_free;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// pixel write
	logic [WW-1:0] wcol;
	logic [WW-1:0] wcol_n;
	logic          do_write;
	assign wcol     = (in_col_q >= eff_w) ? '0 : in_col_q;
	assign wcol_n   = wcol + 1'b1;
	assign do_write = accept && (req_type == REQ_PIXEL) && (in_row_q < eff_h);

	// readiness of the next output
	logic [ROW_W:0] need_r;
	logic [WW:0]    need_c;
	logic           ready;
	always_comb begin
		need_r = {1'b0, out_row_q} + (ROW_W + 1)'(p);
		if (need_r > {1'b0, eff_h - 1'b1}) need_r = {1'b0, eff_h - 1'b1};
		need_c = {1'b0, out_col_q} + (WW + 1)'(p);
		if (need_c > {1'b0, eff_w - 1'b1}) need_c = {1'b0, eff_w - 1'b1};
		ready = (out_row_q < eff_h) && (out_col_q < eff_w)
			&& (({1'b0, in_row_q} > need_r)
			|| (({1'b0, in_row_q} == need_r) && ({1'b0, in_col_q} > need_c)));
	end

	// tap address
	logic signed [ROW_W+1:0] rr;
	logic signed [ROW_W+1:0] dr;
	logic signed [WW+1:0]    cc;
	logic signed [SW+2:0]    sl;
	logic [SW-1:0]           rslot;
	logic [CW-1:0]           rcol;
	logic signed [4:0]       neg_p;
	logic [1:0]              tap_d;
	logic signed [7:0]       wt;
	always_comb begin
		neg_p = -$signed({1'b0, p});
		rr = $signed({2'b0, out_row_q}) + (ROW_W + 2)'(dy_q);
		if (rr < 0) rr = '0;
		if (rr > $signed({2'b0, eff_h - 1'b1})) rr = $signed({2'b0, eff_h - 1'b1});
		dr = rr - $signed({2'b0, out_row_q});
		sl = $signed({3'b0, out_slot_q}) + (SW + 3)'(dr);
		if (sl < 0) sl = sl + $signed({2'b0, slots});
		else if (sl >= $signed({2'b0, slots})) sl = sl - $signed({2'b0, slots});
		rslot = SW'(sl);
		cc = $signed({2'b0, out_col_q}) + (WW + 2)'(dx_q);
		if (cc < 0) cc = '0;
		if (cc > $signed({2'b0, eff_w - 1'b1})) cc = $signed({2'b0, eff_w - 1'b1});
		rcol = CW'(cc);
		tap_d = 2'(dy_q != 0) + 2'(dx_q != 0);
		unique case (mode_q)
			MODE_MEAN:    wt = 8'sd1;
			MODE_SMOOTH:  wt = (tap_d == 2'd0) ? 8'sd4 : (tap_d == 2'd1) ? 8'sd2 : 8'sd1;
			MODE_SHARPEN: wt = (tap_d == 2'd0) ? 8'sd5 : (tap_d == 2'd1) ? -8'sd1 : 8'sd0;
			MODE_GAUSS:   wt = (tap_d == 2'd0) ? 8'sd52 : (tap_d == 2'd1) ? 8'sd32 : 8'sd19;
			default:      wt = 8'sd0;
		endcase
	end

	// line store
	always_ff @(posedge clk) begin
		if (do_write) mem[{in_slot_q, wcol[CW-1:0]}] <= pixel_in;
	end
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[{rslot, rcol}];
		wt_s1    <= wt;
	end

	// mean quotient by reciprocal multiply
	logic [RW-1:0]       recip;
	logic [ACC_W+RW-1:0] prod;
	always_comb begin
		unique case (eff_n)
			4'd5:    recip = RW'((RONE + 24) / 25);
			4'd7:    recip = RW'((RONE + 48) / 49);
			4'd9:    recip = RW'((RONE + 80) / 81);
			4'd11:   recip = RW'((RONE + 120) / 121);
			4'd13:   recip = RW'((RONE + 168) / 169);
			4'd15:   recip = RW'((RONE + 224) / 225);
			default: recip = RW'((RONE + 8) / 9);
		endcase
		prod = $unsigned(acc_q) * (ACC_W + RW)'(recip);
	end

	// result value
	logic [7:0] res_pix;
	always_comb begin
		unique case (mode_q)
			MODE_MEAN:    res_pix = quo_q;
			MODE_SMOOTH:  res_pix = acc_q[11:4];
			MODE_SHARPEN: begin
				if (acc_q < 0) res_pix = 8'd0;
				else if (acc_q > 255) res_pix = 8'd255;
				else res_pix = acc_q[7:0];
			end
			MODE_GAUSS:   res_pix = acc_q[15:8];
			default:      res_pix = 8'd0;
		endcase
	end

	logic              last_tap;
	logic [WW-1:0]     ocol_n;
	logic              orow_wrap;
	logic [ROW_W-1:0]  orow_n;
	assign last_tap  = (dx_q == $signed({1'b0, p})) && (dy_q == $signed({1'b0, p}));
	assign ocol_n    = out_col_q + 1'b1;
	assign orow_wrap = (ocol_n >= eff_w);
	assign orow_n    = out_row_q + 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_type == REQ_PIXEL && in_row_q >= eff_h) state_d = S_RES;
					else state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = ready ? S_READ : S_IDLE;
			S_READ:  if (last_tap) state_d = S_LAST;
			S_LAST:  state_d = (mode_q == MODE_MEAN) ? S_DIV : S_RES;
			S_DIV:   state_d = S_RES;
			S_RES:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 11'd640;
			height_q   <= 13'd480;
			mode_q     <= MODE_MEAN;
			msize_q    <= 3'd3;
			in_row_q   <= '0;
			in_col_q   <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			in_slot_q  <= '0;
			out_slot_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_MSIZE:  msize_q  <= cfg_data[2:0];
				default:    ;
			endcase
			in_row_q   <= '0;
			in_col_q   <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			in_slot_q  <= '0;
			out_slot_q <= '0;
		end else begin
			if (do_write) begin
				if (wcol_n >= eff_w) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 1'b1;
					in_slot_q <= ({1'b0, in_slot_q} == slots - 1'b1) ? '0 : in_slot_q + 1'b1;
				end else begin
					in_col_q <= wcol_n;
				end
			end
			if (state_q == S_RES && out_free && !drop_q) begin
				if (orow_wrap && orow_n >= eff_h) begin
					in_row_q   <= '0;
					in_col_q   <= '0;
					out_row_q  <= '0;
					out_col_q  <= '0;
					in_slot_q  <= '0;
					out_slot_q <= '0;
				end else if (orow_wrap) begin
					out_col_q  <= '0;
					out_row_q  <= orow_n;
					out_slot_q <= ({1'b0, out_slot_q} == slots - 1'b1) ? '0
						: out_slot_q + 1'b1;
				end else begin
					out_col_q <= ocol_n;
				end
			end
		end
	end

	// window walk, accumulate, divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1  <= 1'b0;
			drop_q <= 1'b0;
		end else begin
			rd_s1 <= (state_q == S_READ);
			if (accept) drop_q <= (req_type == REQ_PIXEL) && (in_row_q >= eff_h);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			acc_q <= '0;
			dy_q  <= neg_p;
			dx_q  <= neg_p;
		end else begin
			if (state_q == S_READ) begin
				if (dx_q == $signed({1'b0, p})) begin
					dx_q <= neg_p;
					dy_q <= dy_q + 5'sd1;
				end else begin
					dx_q <= dx_q + 5'sd1;
				end
			end
			if (rd_s1) begin
				acc_q <= acc_q + ACC_W'($signed({1'b0, rdata_s1})) * ACC_W'(wt_s1);
			end
		end
		if (state_q == S_DIV) quo_q <= prod[RSH+7:RSH];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == S_RES && out_free) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RES && out_free) begin
			pix_q  <= drop_q ? 8'd0 : res_pix;
			fend_q <= !drop_q && orow_wrap && (orow_n >= eff_h);
			stat_q <= drop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pix_q;
	assign frame_end = fend_q;
	assign status    = stat_q;

endmodule

### sim/replicate_pad_window_filter_tb.sv
// ----------------------------------------------------------------------------
// replicate_pad_window_filter_tb
// Streams frames of grey pixels and flush requests through the window filter
// under random idling on both sides. Frame sizes, modes and mean sizes vary
// between phases. A local line-store predictor works out each result, and the
// results are checked in order.
// ----------------------------------------------------------------------------
module replicate_pad_window_filter_tb;
	import rpwf_pkg::*;

	typedef struct {
		req_type_t  kind;
		logic [7:0] px;
	} pix_req_t;

	typedef struct {
		logic [7:0] px;
		logic       fe;
		logic       st;
	} filt_res_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [7:0]  pixel_in;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  pixel_out;
	logic        frame_end;
	logic        status;

	replicate_pad_window_filter DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .pixel_in(pixel_in), .out_valid(out_valid),
		.out_stall(out_stall), .pixel_out(pixel_out), .frame_end(frame_end),
		.status(status)
	);

	pix_req_t  pending_reqs[$];
	filt_res_t expected_pixels[$];

	// predictor state
	logic [7:0]   row_ring[0:8*DEF_MAX_WIDTH-1];
	logic [10:0]  width_reg;
	logic [12:0]  height_reg;
	filter_mode_t mode_reg;
	logic [2:0]   msize_reg;
	int unsigned  in_r, in_c, out_r, out_c;

	int errors, accepted_in, checked, drops, frames, pushed, idle_cycles;
	int send_idle_pct, recv_idle_pct, hold_left;
	bit in_taken, hold_done;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned eff_w();
		if (width_reg == 0) return 1;
		if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_h();
		if (height_reg == 0) return 1;
		if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
		return height_reg;
	endfunction

	function automatic int unsigned half_win();
		int unsigned n;
		n = msize_reg;
		if (mode_reg != MODE_MEAN) return 1;
		if (n < 3) n = 3;
		if (n % 2 == 0) n++;
		if (n > DEF_MAX_SIZE) n = DEF_MAX_SIZE;
		return n / 2;
	endfunction

	function automatic int ring_px(int r, int c, int w, int h, int slots);
		if (r < 0) r = 0;
		if (r > h - 1) r = h - 1;
		if (c < 0) c = 0;
		if (c > w - 1) c = w - 1;
		return row_ring[(r % slots) * DEF_MAX_WIDTH + c];
	endfunction

	function automatic logic [7:0] window_value(int w, int h, int p, int slots);
		int acc, wt, d;
		acc = 0;
		if (mode_reg == MODE_MEAN) begin
			for (int dy = -p; dy <= p; dy++)
				for (int dx = -p; dx <= p; dx++)
					acc += ring_px(out_r + dy, out_c + dx, w, h, slots);
			return acc / ((2 * p + 1) * (2 * p + 1));
		end
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				d = (dy != 0) + (dx != 0);
				case (mode_reg)
					MODE_SMOOTH:  wt = (d == 0) ? 4 : (d == 1) ? 2 : 1;
					MODE_SHARPEN: wt = (d == 0) ? 5 : (d == 1) ? -1 : 0;
					default:      wt = (d == 0) ? 52 : (d == 1) ? 32 : 19;
				endcase
				acc += wt * ring_px(out_r + dy, out_c + dx, w, h, slots);
			end
		end
		if (mode_reg == MODE_SMOOTH) return acc / 16;
		if (mode_reg == MODE_SHARPEN) return (acc < 0) ? 0 : (acc > 255) ? 255 : acc;
		return acc / 256;
	endfunction

	task automatic predict_request(input pix_req_t rq);
		int unsigned w, h, p, slots, nr, nc;
		filt_res_t res;
		w = eff_w();
		h = eff_h();
		p = half_win();
		slots = 2 * p + 2;
		res = '{px: 8'd0, fe: 1'b0, st: 1'b0};
		if (rq.kind == REQ_PIXEL) begin
			if (in_r >= h) begin
				res.st = 1'b1;
				expected_pixels.push_back(res);
				return;
			end
			if (in_c >= w) in_c = 0;
			row_ring[(in_r % slots) * DEF_MAX_WIDTH + in_c] = rq.px;
			in_c++;
			if (in_c >= w) begin
				in_c = 0;
				in_r++;
			end
		end
		if (out_r >= h || out_c >= w) return;
		nr = (out_r + p > h - 1) ? h - 1 : out_r + p;
		nc = (out_c + p > w - 1) ? w - 1 : out_c + p;
		if (!(in_r > nr || (in_r == nr && in_c > nc))) return;
		res.px = window_value(w, h, p, slots);
		out_c++;
		if (out_c >= w) begin
			out_c = 0;
			out_r++;
		end
		if (out_r >= h) begin
			res.fe = 1'b1;
			in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		end
		expected_pixels.push_back(res);
	endtask

	// sample both channels
	always @(posedge clk) begin
		filt_res_t e;
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && !in_stall) begin
				predict_request('{kind: req_type_t'(req_type), px: pixel_in});
				in_taken = 1'b1;
				accepted_in++;
				idle_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t unexpected result px=%0d fe=%0b st=%0b", $time,
						pixel_out, frame_end, status);
				end else begin
					e = expected_pixels.pop_front();
					checked++;
					if (e.st) drops++;
					if (e.fe) frames++;
					if (pixel_out !== e.px || frame_end !== e.fe || status !== e.st) begin
						errors++;
						$display("%0t mismatch exp px=%0d fe=%0b st=%0b got px=%0d fe=%0b st=%0b",
							$time, e.px, e.fe, e.st, pixel_out, frame_end, status);
					end
				end
			end
			if (idle_cycles > 20000) begin
				$display("%0t watchdog: no progress", $time);
				$display("[replicate_pad_window_filter] ERROR");
				$finish;
			end
		end
	end

	// drive requests
	always @(negedge clk) begin
		if (accepted_in < 600) begin
			send_idle_pct = 31; recv_idle_pct = 73;
		end else if (accepted_in < 1200) begin
			send_idle_pct = 73; recv_idle_pct = 31;
		end else begin
			send_idle_pct = 0; recv_idle_pct = 0;
		end
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				pix_req_t rq;
				rq = pending_reqs.pop_front();
				in_valid <= 1'b1;
				req_type <= rq.kind;
				pixel_in <= rq.px;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls, with one long hold-off
	always @(negedge clk) begin
		if (!hold_done && accepted_in >= 400) begin
			hold_done = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic logic [7:0] rand_px();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_WIDTH:  width_reg = val[10:0];
			REG_HEIGHT: height_reg = val;
			REG_MODE:   mode_reg = filter_mode_t'(val[1:0]);
			default:    msize_reg = val[2:0];
		endcase
		in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// one phase: configure, send npix pixels, then flushes with some noise
	task automatic run_frame(input int w, input int h, input filter_mode_t m,
		input int ms, input int npix, input int fill);
		int p, tail;
		write_reg(REG_MODE, CFG_W'(m));
		write_reg(REG_MSIZE, CFG_W'(ms));
		write_reg(REG_WIDTH, CFG_W'(w));
		write_reg(REG_HEIGHT, CFG_W'(h));
		p = half_win();
		tail = int'(((eff_h() > p) ? p : eff_h() - 1) * eff_w() + p + 4);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(19) == 0)
				pending_reqs.push_back('{kind: REQ_FLUSH, px: rand_px()});
			pending_reqs.push_back('{kind: REQ_PIXEL,
				px: (fill >= 0) ? 8'(fill) : rand_px()});
		end
		for (int i = 0; i < tail; i++) begin
			if ($urandom_range(9) == 0)
				pending_reqs.push_back('{kind: REQ_PIXEL, px: rand_px()});
			pending_reqs.push_back('{kind: REQ_FLUSH, px: rand_px()});
		end
		pushed += pending_reqs.size();
		drain();
	endtask

	initial begin
		int w, h;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_PIXEL;
		pixel_in = 8'd0;
		out_stall = 1'b0;
		width_reg = 11'd640;
		height_reg = 13'd480;
		mode_reg = MODE_MEAN;
		msize_reg = 3'd3;
		in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		run_frame(3, 3, MODE_MEAN, 3, 9, -1);
		run_frame(3, 3, MODE_SHARPEN, 3, 9, 255);
		run_frame(4, 3, MODE_SMOOTH, 0, 12, -1);
		run_frame(2, 2, MODE_GAUSS, 7, 4, 255);
		run_frame(0, 0, MODE_MEAN, 6, 1, -1);
		run_frame(5, 5, MODE_MEAN, 7, 25, -1);
		run_frame(1, 8191, MODE_SMOOTH, 2, 40, -1);
		run_frame(2047, 1, MODE_SHARPEN, 4, 1024, -1);
		while (pushed < 1700) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(9, 1);
			h = $urandom_range(8, 1);
			run_frame(w, h, filter_mode_t'($urandom_range(3)), $urandom_range(7),
				($urandom_range(7) == 0) ? $urandom_range(w * h) : w * h, -1);
		end
		drain();
		if (expected_pixels.size() != 0) errors++;
		$display("Covered %0d requests, %0d results checked, %0d frames, %0d drops.",
			accepted_in, checked, frames, drops);
		if (errors == 0)
			$display("[replicate_pad_window_filter] OK");
		else
			$display("[replicate_pad_window_filter] ERROR");
		$finish;
	end

endmodule

### files.f
design/rpwf_pkg.sv
design/replicate_pad_window_filter.sv
sim/replicate_pad_window_filter_tb.sv
